@@ rtl/kefa_pkg.sv @@
// Shared types and constants for the keypad event queue with autorepeat.
// Used by kefa_front, kefa_back and the top level; depends on nothing.
package kefa_pkg;

   // Field widths.
   localparam int ACTION_W = 2;
   localparam int KEY_W    = 2;
   localparam int KIND_W   = 2;
   localparam int DELAY_W  = 16;
   localparam int EVENT_W  = KIND_W + KEY_W;

   // Default sizes of the block.
   localparam int DEFAULT_KEY_COUNT   = 4;
   localparam int DEFAULT_QUEUE_DEPTH = 16;

   // Reset value of the repeat delay register.
   localparam logic [DELAY_W-1:0] DEFAULT_REPEAT_DELAY = 16'd100;

   // Request actions.
   localparam logic [ACTION_W-1:0] ACT_PRESS   = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_RELEASE = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_TICK    = 2'd2;
   localparam logic [ACTION_W-1:0] ACT_READ    = 2'd3;

   // Event kinds.
   localparam logic [KIND_W-1:0] KIND_DOWN   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_UP     = 2'd1;
   localparam logic [KIND_W-1:0] KIND_REPEAT = 2'd2;

   // One classified command passed from the front to the back.
   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [KEY_W-1:0]    key;
   } cmd_type;

endpackage

@@ rtl/keypad_event_fifo_autorepeat.sv @@
// Top level of the keypad controller with autorepeat and a bounded event queue.
// Depends on kefa_pkg, kefa_front, kefa_back and kefa_ram.
//
// Usage:
//   Request beats (req_action, req_key) carry a press, release, tick or read.
//   Only a read produces a response beat on the rsp_ channel; it reports the
//   oldest queued event, or event_valid low when the queue is empty, and the
//   events_lost flag, which is cleared by every read. The repeat delay
//   register is written through csr_wr_en / csr_wr_data, only while the
//   block is idle, a user rule it does not enforce; it resets to 100 ticks.
// Timing:
//   Requests enter a two-slot command queue, so up to two beats are taken
//   while the back end is busy. The back end finishes a press, a release or
//   an empty read in its idle state; a read that pops an event also passes
//   through the read state (the event RAM has a registered read), and a tick
//   walks the keys in turn in the tick state. An empty read's response is
//   registered in the cycle after it starts, a pop's from the read state.
// Reset and stall:
//   Synchronous reset empties the queue and clears all key state at once.
//   A stalled response holds its register; the next read then waits at the
//   head of the command queue and holds back every beat queued behind it.
module keypad_event_fifo_autorepeat #(
   parameter int KEY_COUNT   = kefa_pkg::DEFAULT_KEY_COUNT,
   parameter int QUEUE_DEPTH = kefa_pkg::DEFAULT_QUEUE_DEPTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic [kefa_pkg::DELAY_W-1:0]  csr_wr_data,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [kefa_pkg::ACTION_W-1:0] req_action,
   input  logic [kefa_pkg::KEY_W-1:0]    req_key,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_event_valid,
   output logic [kefa_pkg::KIND_W-1:0]   rsp_event_kind,
   output logic [kefa_pkg::KEY_W-1:0]    rsp_event_key,
   output logic                          rsp_events_lost
);
   import kefa_pkg::*;

   logic    cmd_valid;
   logic    cmd_ready;
   cmd_type cmd;

   // Accept and classify requests.
   kefa_front #(
      .KEY_COUNT (KEY_COUNT)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_action (req_action),
      .req_key    (req_key),
      .cmd_valid  (cmd_valid),
      .cmd        (cmd),
      .cmd_ready  (cmd_ready)
   );

   // Execute commands and return read results.
   kefa_back #(
      .KEY_COUNT   (KEY_COUNT),
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .cmd_valid       (cmd_valid),
      .cmd             (cmd),
      .cmd_ready       (cmd_ready),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_event_valid (rsp_event_valid),
      .rsp_event_kind  (rsp_event_kind),
      .rsp_event_key   (rsp_event_key),
      .rsp_events_lost (rsp_events_lost)
   );

endmodule

@@ rtl/kefa_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Stands alone; no package needed.
module kefa_ram #(
   parameter int WIDTH = 4,
   parameter int DEPTH = 16,
   localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AddrW-1:0] wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AddrW-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/kefa_front.sv @@
// Front end: accepts request beats, drops presses and releases of keys that
// do not exist, and holds the rest in a two-slot command queue. Uses kefa_pkg.
module kefa_front #(
   parameter int KEY_COUNT = kefa_pkg::DEFAULT_KEY_COUNT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [kefa_pkg::ACTION_W-1:0]      req_action,
   input  logic [kefa_pkg::KEY_W-1:0]         req_key,
   output logic                               cmd_valid,
   output kefa_pkg::cmd_type                  cmd,
   input  logic                               cmd_ready
);
   import kefa_pkg::*;

   localparam logic [1:0] SlotsFull = 2'd2;

   cmd_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       key_ok;
   logic       keep;
   logic       push;
   logic       pop;

   // Classify: a press or release of a key beyond the keypad is dropped.
   assign key_ok    = (int'(req_key) < KEY_COUNT);
   assign keep      = !((req_action == ACT_PRESS) || (req_action == ACT_RELEASE)) || key_ok;
   assign req_ready = (count_ff != SlotsFull);
   assign push      = req_valid && req_ready && keep;

   // Queue outputs toward the back end.
   assign cmd_valid = (count_ff != 2'd0);
   assign cmd       = slot_ff[rd_ptr_ff];
   assign pop       = cmd_valid && cmd_ready;

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Command slots hold payload only.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= '{action: req_action, key: req_key};
      end
   end

endmodule

@@ rtl/kefa_back.sv @@
// Back end: executes commands against the key state and the event queue,
// walks the keys on a tick and drives the response register.
// Uses kefa_pkg and kefa_ram.
module kefa_back #(
   parameter int KEY_COUNT   = kefa_pkg::DEFAULT_KEY_COUNT,
   parameter int QUEUE_DEPTH = kefa_pkg::DEFAULT_QUEUE_DEPTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic [kefa_pkg::DELAY_W-1:0]  csr_wr_data,
   input  logic                          cmd_valid,
   input  kefa_pkg::cmd_type             cmd,
   output logic                          cmd_ready,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_event_valid,
   output logic [kefa_pkg::KIND_W-1:0]   rsp_event_kind,
   output logic [kefa_pkg::KEY_W-1:0]    rsp_event_key,
   output logic                          rsp_events_lost
);
   import kefa_pkg::*;

   localparam int IdxW = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
   localparam int PtrW = $clog2(QUEUE_DEPTH);
   localparam int CntW = $clog2(QUEUE_DEPTH + 1);
   localparam logic [IdxW-1:0] LastIdx = IdxW'(KEY_COUNT - 1);
   localparam logic [PtrW-1:0] LastPtr = PtrW'(QUEUE_DEPTH - 1);
   localparam logic [CntW-1:0] FullCnt = CntW'(QUEUE_DEPTH);

   // Back end states.
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_TICK = 2'd1;
   localparam logic [1:0] ST_READ = 2'd2;

   logic [1:0]           state_ff, state_in;
   logic [IdxW-1:0]      tick_idx_ff, tick_idx_in;
   logic [DELAY_W-1:0]   delay_ff, delay_in;
   logic [KEY_COUNT-1:0] held_ff, held_in;
   logic [KEY_COUNT-1:0] pend_ff, pend_in;
   logic [DELAY_W-1:0]   hold_cnt_ff [KEY_COUNT];
   logic [DELAY_W-1:0]   hold_cnt_in [KEY_COUNT];
   logic [PtrW-1:0]      head_ff, head_in;
   logic [PtrW-1:0]      tail_ff, tail_in;
   logic [CntW-1:0]      count_ff, count_in;
   logic                 lost_ff, lost_in;
   logic                 read_lost_ff, read_lost_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_event_valid_ff, rsp_event_valid_in;
   logic [KIND_W-1:0]    rsp_kind_ff, rsp_kind_in;
   logic [KEY_W-1:0]     rsp_key_ff, rsp_key_in;
   logic                 rsp_lost_ff, rsp_lost_in;

   logic [KEY_COUNT-1:0] key_bit;
   logic                 push_en;
   logic [KIND_W-1:0]    push_kind;
   logic [KEY_W-1:0]     push_key;
   logic                 ram_wr_en;
   logic                 ram_rd_en;
   logic [EVENT_W-1:0]   ram_rd_data;

   assign key_bit = KEY_COUNT'(1) << cmd.key;

   // Command execution, tick walk and queue bookkeeping.
   always_comb begin
      state_in           = state_ff;
      tick_idx_in        = tick_idx_ff;
      delay_in           = csr_wr_en ? csr_wr_data : delay_ff;
      held_in            = held_ff;
      pend_in            = pend_ff;
      hold_cnt_in        = hold_cnt_ff;
      head_in            = head_ff;
      tail_in            = tail_ff;
      count_in           = count_ff;
      lost_in            = lost_ff;
      read_lost_in       = read_lost_ff;
      rsp_valid_in       = rsp_valid_ff && !rsp_ready;
      rsp_event_valid_in = rsp_event_valid_ff;
      rsp_kind_in        = rsp_kind_ff;
      rsp_key_in         = rsp_key_ff;
      rsp_lost_in        = rsp_lost_ff;
      cmd_ready          = 1'b0;
      push_en            = 1'b0;
      push_kind          = KIND_DOWN;
      push_key           = '0;
      ram_rd_en          = 1'b0;
      ram_wr_en          = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               unique case (cmd.action)
                  ACT_PRESS: begin
                     cmd_ready = 1'b1;
                     held_in   = held_ff | key_bit;
                     push_en   = 1'b1;
                     push_kind = KIND_DOWN;
                     push_key  = cmd.key;
                  end
                  ACT_RELEASE: begin
                     cmd_ready = 1'b1;
                     held_in   = held_ff & ~key_bit;
                     push_en   = 1'b1;
                     push_kind = KIND_UP;
                     push_key  = cmd.key;
                  end
                  ACT_TICK: begin
                     cmd_ready   = 1'b1;
                     tick_idx_in = '0;
                     state_in    = ST_TICK;
                  end
                  ACT_READ: begin
                     // A read waits until the response register is free.
                     if (!rsp_valid_ff) begin
                        cmd_ready = 1'b1;
                        lost_in   = 1'b0;
                        if (count_ff == '0) begin
                           pend_in            = '0;
                           rsp_valid_in       = 1'b1;
                           rsp_event_valid_in = 1'b0;
                           rsp_kind_in        = '0;
                           rsp_key_in         = '0;
                           rsp_lost_in        = lost_ff;
                        end else begin
                           ram_rd_en    = 1'b1;
                           head_in      = (head_ff == LastPtr) ? '0 : head_ff + 1'b1;
                           count_in     = count_ff - 1'b1;
                           read_lost_in = lost_ff;
                           state_in     = ST_READ;
                        end
                     end
                  end
               endcase
            end
         end
         ST_TICK: begin
            // One key per cycle.
            if (held_ff[tick_idx_ff]) begin
               if (hold_cnt_ff[tick_idx_ff] < delay_ff) begin
                  hold_cnt_in[tick_idx_ff] = hold_cnt_ff[tick_idx_ff] + 1'b1;
               end else if (!pend_ff[tick_idx_ff]) begin
                  push_en               = 1'b1;
                  push_kind             = KIND_REPEAT;
                  push_key              = KEY_W'(tick_idx_ff);
                  pend_in[tick_idx_ff]  = 1'b1;
               end
            end else begin
               hold_cnt_in[tick_idx_ff] = '0;
            end
            if (tick_idx_ff == LastIdx) begin
               state_in = ST_IDLE;
            end else begin
               tick_idx_in = tick_idx_ff + 1'b1;
            end
         end
         ST_READ: begin
            // The queue entry arrives from the RAM this cycle.
            rsp_valid_in       = 1'b1;
            rsp_event_valid_in = 1'b1;
            rsp_kind_in        = ram_rd_data[EVENT_W-1:KEY_W];
            rsp_key_in         = ram_rd_data[KEY_W-1:0];
            rsp_lost_in        = read_lost_ff;
            state_in           = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Append an event, or drop it and flag the loss when the queue is full.
      if (push_en) begin
         if (count_ff >= FullCnt) begin
            lost_in = 1'b1;
         end else begin
            ram_wr_en = 1'b1;
            tail_in   = (tail_ff == LastPtr) ? '0 : tail_ff + 1'b1;
            count_in  = count_ff + 1'b1;
         end
      end
   end

   // Control and key state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         tick_idx_ff  <= '0;
         delay_ff     <= DEFAULT_REPEAT_DELAY;
         held_ff      <= '0;
         pend_ff      <= '0;
         hold_cnt_ff  <= '{default: '0};
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         lost_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tick_idx_ff  <= tick_idx_in;
         delay_ff     <= delay_in;
         held_ff      <= held_in;
         pend_ff      <= pend_in;
         hold_cnt_ff  <= hold_cnt_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         lost_ff      <= lost_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Response payload registers.
   always_ff @(posedge clock) begin
      read_lost_ff       <= read_lost_in;
      rsp_event_valid_ff <= rsp_event_valid_in;
      rsp_kind_ff        <= rsp_kind_in;
      rsp_key_ff         <= rsp_key_in;
      rsp_lost_ff        <= rsp_lost_in;
   end

   // Event storage.
   kefa_ram #(
      .WIDTH (EVENT_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_event_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (tail_ff),
      .wr_data ({push_kind, push_key}),
      .rd_en   (ram_rd_en),
      .rd_addr (head_ff),
      .rd_data (ram_rd_data)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_event_valid = rsp_event_valid_ff;
   assign rsp_event_kind  = rsp_kind_ff;
   assign rsp_event_key   = rsp_key_ff;
   assign rsp_events_lost = rsp_lost_ff;

`ifndef SYNTHESIS
   // The fill count never passes the queue depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FullCnt)
      else $error("event queue count above depth");

   // An empty queue has its pointers together.
   a_empty_ptrs: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (head_ff == tail_ff))
      else $error("empty queue with head and tail apart");

   // A queue read is only started when the response register is free.
   a_read_slot: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |-> !rsp_valid_ff)
      else $error("queue read while response register busy");

   // An empty read returns zero kind and key.
   a_empty_rsp: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_event_valid_ff) |-> (rsp_kind_ff == '0 && rsp_key_ff == '0))
      else $error("empty read with nonzero fields");

   // An event pushed into a full queue sets the lost flag.
   a_drop_flag: assert property (@(posedge clock) disable iff (reset)
      (push_en && count_ff == FullCnt) |=> lost_ff)
      else $error("dropped event did not set lost flag");
`endif

endmodule
